[rtl/core/fpd_pkg.sv]
`default_nettype none

package fpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int STATUS_W   = 3;

  // bytes shown on the result ports
  localparam int OUT_BYTES  = 11;
  localparam int LOW_BYTES  = 8;
  localparam int LOW_W      = LOW_BYTES * BYTE_W;
  localparam int HIGH_W     = (OUT_BYTES - LOW_BYTES) * BYTE_W;

  localparam logic [POS_W-1:0] BUTTONS_POS = POS_W'(2);
  localparam logic [POS_W-1:0] HAT_POS     = POS_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'd171;
  localparam logic [BYTE_W-1:0] TIMEOUT_RST = 8'd100;
  localparam logic [BYTE_W-1:0] BUTTONS_RST = 8'd63;
  localparam logic [BYTE_W-1:0] HAT_RST     = 8'd8;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BUTTONS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HAT     = CFG_IDX_W'(3);

  typedef enum logic [STATUS_W-1:0] {
    ST_NODATA  = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_HEADER  = 3'd2,
    ST_BUTTONS = 3'd3,
    ST_HAT     = 3'd4,
    ST_PARTIAL = 3'd5,
    ST_DONE    = 3'd6
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] timeout_limit;
    logic [BYTE_W-1:0] buttons_max;
    logic [BYTE_W-1:0] hat_max;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/fpd_cfg_regs.sv]
`default_nettype none

module fpd_cfg_regs
  import fpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [BYTE_W-1:0]    wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value  <= HEADER_RST;
      cfg_r.timeout_limit <= TIMEOUT_RST;
      cfg_r.buttons_max   <= BUTTONS_RST;
      cfg_r.hat_max       <= HAT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEADER:  cfg_r.header_value  <= wr_data;
        REG_TIMEOUT: cfg_r.timeout_limit <= wr_data;
        REG_BUTTONS: cfg_r.buttons_max   <= wr_data;
        REG_HAT:     cfg_r.hat_max       <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/core/fixed_packet_deframer.sv]
// the result of each input transfer is registered in the output register
// throughput: one input item per cycle while in_stall is low; the result register is the only stage
// input stalls only while a result waits in the output register and out_stall is high
// reset: configuration to defaults, position and stall count to zero, output empty
// the byte store is not reset; every byte is written before a packet is emitted
`default_nettype none

module fixed_packet_deframer
  import fpd_pkg::*;
#(
  parameter int PACKET_BYTES = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic [LOW_W-1:0]          out_packet_low,
  output logic [HIGH_W-1:0]         out_packet_high,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  // the last byte comes straight from the input, so it is never stored
  localparam int STORE_DEPTH = PACKET_BYTES - 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  cfg_t cfg;

  logic [BYTE_W-1:0] store_r [STORE_DEPTH];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic              wr_en;
  status_t           st_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r;
  logic [LOW_W-1:0]  packet_low_r;
  logic [HIGH_W-1:0] packet_high_r;

  logic [BYTE_W-1:0] pkt_byte [OUT_BYTES];
  logic [LOW_W-1:0]  pkt_low;
  logic [HIGH_W-1:0] pkt_high;
  logic              acc;

  assign cfg_ready = 1'b1;

  fpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    st_nxt  = ST_NODATA;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    wr_en   = 1'b0;
    if (in_func) begin
      if (pos_r != '0) begin
        if (cnt_inc > {1'b0, cfg.timeout_limit}) begin
          st_nxt  = ST_TIMEOUT;
          pos_nxt = '0;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end else if (pos_r == '0 && in_rx_byte != cfg.header_value) begin
      st_nxt = ST_HEADER;
    end else if (pos_r == BUTTONS_POS && in_rx_byte > cfg.buttons_max) begin
      st_nxt  = ST_BUTTONS;
      pos_nxt = '0;
    end else if (pos_r == HAT_POS && in_rx_byte > cfg.hat_max) begin
      st_nxt  = ST_HAT;
      pos_nxt = '0;
    end else if (pos_r != LAST_POS) begin
      st_nxt  = ST_PARTIAL;
      wr_en   = 1'b1;
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      st_nxt  = ST_DONE;
      pos_nxt = '0;
    end
  end

  // packet bytes past the configured length read as zero
  for (genvar g = 0; g < OUT_BYTES; g++) begin : g_pkt
    if (g < STORE_DEPTH) begin : g_store
      assign pkt_byte[g] = store_r[g];
    end else if (g == STORE_DEPTH) begin : g_last
      assign pkt_byte[g] = in_rx_byte;
    end else begin : g_zero
      assign pkt_byte[g] = '0;
    end
    if (g < LOW_BYTES) begin : g_low
      assign pkt_low[g*BYTE_W +: BYTE_W] = pkt_byte[g];
    end else begin : g_high
      assign pkt_high[(g-LOW_BYTES)*BYTE_W +: BYTE_W] = pkt_byte[g];
    end
  end

  assign out_valid_nxt = acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      store_r[pos_r[IDX_W-1:0]] <= in_rx_byte;
    end
    if (acc) begin
      status_r      <= st_nxt;
      packet_low_r  <= (st_nxt == ST_DONE) ? pkt_low : '0;
      packet_high_r <= (st_nxt == ST_DONE) ? pkt_high : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_packet_low  = packet_low_r;
  assign out_packet_high = packet_high_r;

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st_nxt == ST_DONE) |=> (pos_r == '0))
    else $error("packet done did not return to start");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st_nxt == ST_TIMEOUT) |=> (cnt_r == '0 && pos_r == '0))
    else $error("timeout did not clear count and position");

  a_stall_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_func && pos_r != '0 && st_nxt == ST_NODATA) |=> (cnt_r != '0))
    else $error("mid-packet failed read not counted");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(status_r)))
    else $error("waiting result lost");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (pos_r <= LAST_POS))
    else $error("position beyond packet length");

endmodule

`default_nettype wire

[sim/fixed_packet_deframer_tb.sv]
module fixed_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  localparam int PKT_LEN        = 11;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int N_DIRECTED     = 28;

  // first index past the register map
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(4);

  typedef struct packed {
    status_t           status;
    logic [LOW_W-1:0]  low;
    logic [HIGH_W-1:0] high;
  } frame_result_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 func;
    logic [BYTE_W-1:0]    data;
    logic [CFG_IDX_W-1:0] idx;
    logic                 typed;
    status_t              status;
    logic [LOW_W-1:0]     low;
    logic [HIGH_W-1:0]    high;
  } directed_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTS} rx_mode_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_ITEM,  1'b1, 8'hFF, '0,          1'b1, ST_NODATA,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h00, '0,          1'b1, ST_HEADER,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hFF, '0,          1'b1, ST_HEADER,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hAB, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b1, 8'hFF, '0,          1'b1, ST_NODATA,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hFF, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h40, '0,          1'b1, ST_BUTTONS, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hAB, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h00, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h3F, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h09, '0,          1'b1, ST_HAT,     64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hAB, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h5A, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h00, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h08, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h11, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h22, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h33, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h44, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h55, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h66, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'h77, '0,          1'b1, ST_DONE,
      64'h4433_2211_0800_5AAB, 24'h77_6655},
    // a zero limit lies below the count left by the earlier failed read
    '{ROW_WRITE, 1'b0, 8'h00, REG_TIMEOUT, 1'b0, ST_NODATA,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hAB, '0,          1'b1, ST_PARTIAL, 64'h0, 24'h0},
    '{ROW_ITEM,  1'b1, 8'h00, '0,          1'b1, ST_TIMEOUT, 64'h0, 24'h0},
    '{ROW_WRITE, 1'b0, 8'h00, REG_UNUSED,  1'b0, ST_NODATA,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b0, 8'hAB, '0,          1'b0, ST_NODATA,  64'h0, 24'h0},
    '{ROW_ITEM,  1'b1, 8'h5A, '0,          1'b0, ST_NODATA,  64'h0, 24'h0}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 in_func    = 1'b0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [LOW_W-1:0]     out_packet_low;
  logic [HIGH_W-1:0]    out_packet_high;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  // travels with each input item: a hand-typed result replaces the predicted one
  logic                 item_typed  = 1'b0;
  frame_result_t        item_result = '0;

  // predictor state
  cfg_t                 regs = '{HEADER_RST, TIMEOUT_RST, BUTTONS_RST, HAT_RST};
  logic [POS_W-1:0]     frame_pos = '0;
  logic [CNT_W-1:0]     stall_cnt = '0;
  logic [BYTE_W-1:0]    frame_bytes [PKT_LEN];
  frame_result_t        pending_results [$];

  int unsigned fail_count  = 0;
  int unsigned sent_items  = 0;
  int unsigned cfg_writes  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 3;
  int unsigned results_by_status [8] = '{default: 0};

  rx_mode_t    rx_mode      = RX_FREE;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick      = 0;

  always #2 clk = ~clk;

  fixed_packet_deframer #(
    .PACKET_BYTES (PKT_LEN)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_packet_low  (out_packet_low),
    .out_packet_high (out_packet_high),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  function automatic frame_result_t next_frame_result(input logic failed,
                                                      input logic [BYTE_W-1:0] b);
    frame_result_t r;
    r = '0;
    r.status = ST_NODATA;
    if (frame_pos >= PKT_LEN) frame_pos = '0;
    if (failed) begin
      // failed reads only count once a packet has started
      if (frame_pos != '0) begin
        if (stall_cnt != CNT_MAX) stall_cnt++;
        if (stall_cnt > regs.timeout_limit) begin
          frame_pos = '0;
          stall_cnt = '0;
          r.status  = ST_TIMEOUT;
        end
      end
    end else if (frame_pos == '0 && b != regs.header_value) begin
      r.status = ST_HEADER;
    end else if (frame_pos == BUTTONS_POS && b > regs.buttons_max) begin
      frame_pos = '0;
      r.status  = ST_BUTTONS;
    end else if (frame_pos == HAT_POS && b > regs.hat_max) begin
      frame_pos = '0;
      r.status  = ST_HAT;
    end else begin
      frame_bytes[frame_pos] = b;
      if (frame_pos != POS_W'(PKT_LEN - 1)) begin
        frame_pos++;
        r.status = ST_PARTIAL;
      end else begin
        for (int i = 0; i < LOW_BYTES && i < PKT_LEN; i++)
          r.low[BYTE_W*i +: BYTE_W] = frame_bytes[i];
        for (int i = LOW_BYTES; i < OUT_BYTES && i < PKT_LEN; i++)
          r.high[BYTE_W*(i-LOW_BYTES) +: BYTE_W] = frame_bytes[i];
        frame_pos = '0;
        r.status  = ST_DONE;
      end
    end
    return r;
  endfunction

  // receiver: stall behaviour switches between free, light, heavy and burst modes
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(40, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      RX_HEAVY: out_stall <= 1'($urandom_range(0, 1));
      default:  out_stall <= ((rx_tick % 11) < 4);
    endcase
  end

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst_n) begin
      // check the result first, so an item accepted at this edge never matches it
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with status %0d while none is expected", out_status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          results_by_status[int'(want.status)]++;
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_packet_low !== want.low) begin
            $error("packet_low: expected %h, got %h", want.low, out_packet_low);
            fail_count++;
          end
          if (out_packet_high !== want.high) begin
            $error("packet_high: expected %h, got %h", want.high, out_packet_high);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = next_frame_result(in_func, in_rx_byte);
        if (item_typed) want = item_result;
        pending_results.push_back(want);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
        $display("fixed_packet_deframer_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(input logic func, input logic [BYTE_W-1:0] b,
                           input logic typed = 1'b0, input frame_result_t res = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_func     <= func;
    in_rx_byte  <= b;
    item_typed  <= typed;
    item_result <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // hold the sender off until every result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_HEADER:  regs.header_value  = val;
      REG_TIMEOUT: regs.timeout_limit = val;
      REG_BUTTONS: regs.buttons_max   = val;
      REG_HAT:     regs.hat_max       = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_setting(input int unsigned span);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom_range(0, span));
    endcase
  endfunction

  // one packet, mostly well formed; returns the number of items that moved the block
  task automatic send_frame(output int unsigned moved);
    int unsigned       kind;
    int unsigned       cut;
    int unsigned       stalls;
    int unsigned       bad_at;
    int unsigned       n;
    logic              f;
    logic [BYTE_W-1:0] b;
    kind   = $urandom_range(0, 99);
    cut    = PKT_LEN;
    stalls = 0;
    bad_at = PKT_LEN;
    moved  = 0;
    if (kind < 8) begin
      // line noise; a failed read at packet start changes nothing
      repeat ($urandom_range(1, 6)) begin
        f = ($urandom_range(0, 3) == 0);
        b = BYTE_W'($urandom);
        send_item(f, b);
        if (!f) moved++;
      end
      return;
    end
    if (kind < 16)
      cut = $urandom_range(1, PKT_LEN - 1);
    else if (kind < 24)
      stalls = $urandom_range(0, int'(regs.timeout_limit) + 2);
    else if (kind < 30)
      bad_at = 0;
    else if (kind < 36 && regs.buttons_max != '1)
      bad_at = BUTTONS_POS;
    else if (kind < 42 && regs.hat_max != '1)
      bad_at = HAT_POS;
    if (bad_at < PKT_LEN) cut = bad_at + 1;
    for (int unsigned i = 0; i < cut; i++) begin
      b = BYTE_W'($urandom);
      if (i == 0)
        b = (bad_at == 0) ? regs.header_value ^ BYTE_W'($urandom_range(1, 255))
                          : regs.header_value;
      else if (i == BUTTONS_POS)
        b = (bad_at == i) ? BYTE_W'($urandom_range(int'(regs.buttons_max) + 1, 255))
                          : BYTE_W'($urandom_range(0, int'(regs.buttons_max)));
      else if (i == HAT_POS)
        b = (bad_at == i) ? BYTE_W'($urandom_range(int'(regs.hat_max) + 1, 255))
                          : BYTE_W'($urandom_range(0, int'(regs.hat_max)));
      send_item(1'b0, b);
      moved++;
      // failed reads inside the packet: a long run after byte one, else the odd one
      if (i + 1 < cut) begin
        n = (i == 1 && stalls != 0) ? stalls : ($urandom_range(0, 15) == 0);
        repeat (n) begin
          send_item(1'b1, BYTE_W'($urandom));
          moved++;
        end
      end
    end
  endtask

  initial begin
    directed_row_t row;
    frame_result_t typed_res;
    cfg_t          s;
    int unsigned   moved;
    int unsigned   phase_items;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        typed_res = '{row.status, row.low, row.high};
        send_item(row.func, row.data, row.typed, typed_res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       s = '{HEADER_RST, TIMEOUT_RST, BUTTONS_RST, HAT_RST};
        1:       s = '0;
        2:       s = '1;
        default: s = '{pick_setting(255), pick_setting(12), pick_setting(255),
                       pick_setting(15)};
      endcase
      write_reg(REG_HEADER,  s.header_value);
      write_reg(REG_TIMEOUT, s.timeout_limit);
      write_reg(REG_BUTTONS, s.buttons_max);
      write_reg(REG_HAT,     s.hat_max);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNUSED), (1 << CFG_IDX_W) - 1)),
                  BYTE_W'($urandom));
      gap_max     = (p % 3 == 0) ? 0 : $urandom_range(2, 12);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_frame(moved);
        phase_items += moved;
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    $display("%0d input transfers, %0d register writes, %0d packets completed",
             sent_items, cfg_writes, results_by_status[int'(ST_DONE)]);
    $display("%0d timeouts, %0d header, %0d buttons and %0d hat range errors",
             results_by_status[int'(ST_TIMEOUT)], results_by_status[int'(ST_HEADER)],
             results_by_status[int'(ST_BUTTONS)], results_by_status[int'(ST_HAT)]);
    if (fail_count == 0)
      $display("fixed_packet_deframer_tb OK");
    else
      $display("fixed_packet_deframer_tb NOT OK");
    $finish;
  end

endmodule

[fixed_packet_deframer.f]
rtl/core/fpd_pkg.sv
rtl/core/fpd_cfg_regs.sv
rtl/core/fixed_packet_deframer.sv
sim/fixed_packet_deframer_tb.sv
